/* hdl/omkp_pkg.sv */
// Shared types and constants for the offset multiset k-th/purge core.
// Used by offset_multiset_kth_purge_core.
`default_nettype none
package omkp_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_RAISE  = 2'd1,
    OP_LOWER  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_QRY_RD,
    S_QRY_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [30:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [30:0] result_value;
    logic        found;
    logic        insert_full;
    logic [10:0] occupancy;
    logic [31:0] dropped_total;
  } out_item_t;

endpackage
`default_nettype wire

/* hdl/offset_multiset_kth_purge_core.sv */
// Top level of the offset multiset core: sequencer, offset/count registers, result register.
// Depends on omkp_pkg and omkp_store.
//
// Keeps a sorted multiset in a ring-buffer RAM, each entry stored as value minus a global
// offset. One request is worked at a time; the result register lets the next request be
// taken while the previous result still waits downstream. With n the occupancy and k the
// number of search probes (at most ceil(log2(n+1))): raise, refused or ignored insert and
// out-of-range query go straight to the result; a query does one RAM read, then a compare;
// lower-and-purge runs a binary search, each probe a registered RAM read then a compare;
// an insert searches the same way, then every entry above the insert position p is
// moved up one slot by a read then a write on the single RAM port pair.
// Purging costs no moves: the ring head simply advances past the dropped entries. Reads and
// writes of the RAM are sequenced in separate states, so no forwarding is needed.
`default_nettype none
module offset_multiset_kth_purge_core
  import omkp_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [30:0] cfg_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ((VALUE_BITS > 32) ? VALUE_BITS : 32) + 2;
  localparam logic signed [EW-1:0] OFF_MAX = EW'((65'd1 << (VALUE_BITS - 1)) - 65'd1);
  localparam logic signed [EW-1:0] OFF_MIN = -OFF_MAX - EW'(1);
  localparam logic [CW:0] CAP_W = (CW + 1)'(CAPACITY);

  state_t state, state_next;

  // control / architectural state
  logic [CW-1:0]                 held;
  logic [AW-1:0]                 head;
  logic signed [VALUE_BITS-1:0]  offset;
  logic [31:0]                   admitted;
  logic [30:0]                   floor_value;

  // per-request working registers
  op_t                 op_r;
  logic [30:0]         x_r;
  logic signed [EW-1:0] key;
  logic [CW-1:0]       lo, hi, idx;
  logic [30:0]         rv_r;
  logic                found_r, full_r;

  // RAM port
  logic                rd_en, wr_en;
  logic [CW-1:0]       rd_log, wr_log;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [EW-1:0]       rd_raw, wr_data;
  logic signed [EW-1:0] rd_val;

  logic                 accept;
  logic [CW-1:0]        mid;
  logic signed [EW-1:0] off_ext, x_ext, off_sum, off_dif, off_new_raise, off_new_lower;
  logic                 rank_ok, lo_side;
  logic signed [EW:0]   qv;
  logic [31:0]          held_ext;

  // logical index to ring address; the sum stays below twice the capacity
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW + 1)'(h) + (CW + 1)'(l);
    if (s >= CAP_W) s = s - CAP_W;
    return AW'(s);
  endfunction

  function automatic logic signed [EW-1:0] sat_off(input logic signed [EW-1:0] v);
    if (v > OFF_MAX) return OFF_MAX;
    if (v < OFF_MIN) return OFF_MIN;
    return v;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;

  assign off_ext  = EW'(offset);
  assign x_ext    = EW'(in_data.operand);
  assign off_sum  = off_ext + x_ext;
  assign off_dif  = off_ext - x_ext;
  assign off_new_raise = sat_off(off_sum);
  assign off_new_lower = sat_off(off_dif);
  assign rank_ok  = (in_data.operand != 31'd0) && (32'(in_data.operand) <= 32'(held));
  assign mid      = lo + ((hi - lo) >> 1);
  assign rd_val   = rd_raw;
  // strict search for inserts (new value after equals), non-strict for purge
  assign lo_side  = (op_r == OP_INSERT) ? (rd_val <= key) : (rd_val < key);
  assign qv       = (EW + 1)'(rd_val) + (EW + 1)'(offset);
  assign held_ext = 32'(held);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.op)
            OP_RAISE:  state_next = S_DONE;
            OP_LOWER:  state_next = S_PREP;
            OP_INSERT: begin
              if (in_data.operand < floor_value || 32'(held) >= 32'(CAPACITY))
                state_next = S_DONE;
              else
                state_next = S_PREP;
            end
            OP_QUERY:  state_next = rank_ok ? S_QRY_RD : S_DONE;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_PREP:     state_next = S_SRCH_RD;
      S_SRCH_RD: begin
        if (lo < hi)                state_next = S_SRCH_CMP;
        else if (op_r == OP_INSERT) state_next = S_SHIFT_RD;
        else                        state_next = S_DONE;
      end
      S_SRCH_CMP: state_next = S_SRCH_RD;
      S_SHIFT_RD: state_next = (idx > lo) ? S_SHIFT_WR : S_DONE;
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_QRY_RD:   state_next = S_QRY_CMP;
      S_QRY_CMP:  state_next = S_DONE;
      S_DONE:     state_next = (!out_valid || !out_stall) ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    rd_en   = 1'b0;
    rd_log  = mid;
    wr_en   = 1'b0;
    wr_log  = idx;
    wr_data = rd_raw;
    unique case (state)
      S_SRCH_RD:  rd_en = (lo < hi);
      S_SHIFT_RD: begin
        if (idx > lo) begin
          rd_en  = 1'b1;
          rd_log = idx - CW'(1);
        end else begin
          wr_en   = 1'b1;       // drop the new entry into the gap
          wr_data = key;
        end
      end
      S_SHIFT_WR: wr_en = 1'b1; // entry idx-1 moves up to idx
      S_QRY_RD: begin
        rd_en  = 1'b1;
        rd_log = held - CW'(x_r);
      end
      default: ;
    endcase
    rd_addr = phys(head, rd_log);
    wr_addr = phys(head, wr_log);
  end

  omkp_store #(.DEPTH(CAPACITY), .EW(EW), .AW(AW)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      held        <= '0;
      head        <= '0;
      offset      <= '0;
      admitted    <= '0;
      floor_value <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) floor_value <= cfg_data;
      if (state == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall)                   out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && in_data.op == OP_RAISE) offset <= VALUE_BITS'(off_new_raise);
          if (accept && in_data.op == OP_LOWER) offset <= VALUE_BITS'(off_new_lower);
        end
        S_SRCH_RD: begin
          if (!(lo < hi) && op_r == OP_LOWER) begin
            head <= phys(head, lo);
            held <= held - lo;
          end
        end
        S_SHIFT_RD: begin
          if (!(idx > lo)) begin
            held <= held + CW'(1);
            if (admitted != '1) admitted <= admitted + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_r    <= in_data.op;
          x_r     <= in_data.operand;
          rv_r    <= '0;
          found_r <= 1'b0;
          full_r  <= (in_data.op == OP_INSERT) && (in_data.operand >= floor_value)
                     && (32'(held) >= 32'(CAPACITY));
        end
      end
      S_PREP: begin
        if (op_r == OP_INSERT) key <= EW'(x_r) - off_ext;
        else                   key <= EW'(floor_value) - off_ext;
        lo <= '0;
        hi <= held;
      end
      S_SRCH_RD: idx <= held;
      S_SRCH_CMP: begin
        if (lo_side) lo <= mid + CW'(1);
        else         hi <= mid;
      end
      S_SHIFT_WR: idx <= idx - CW'(1);
      S_QRY_CMP: begin
        found_r <= 1'b1;
        if (qv < 0)                         rv_r <= '0;
        else if (qv > (EW + 1)'(32'h7FFF_FFFF)) rv_r <= 31'h7FFF_FFFF;
        else                                rv_r <= 31'(qv);
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_data.result_value  <= rv_r;
          out_data.found         <= found_r;
          out_data.insert_full   <= full_r;
          out_data.occupancy     <= held_ext[10:0];
          out_data.dropped_total <= (admitted > held_ext) ? admitted - held_ext : 32'd0;
        end
      end
      default: ;
    endcase
  end

  // occupancy never passes the capacity
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    32'(held) <= 32'(CAPACITY))
    else $error("occupancy above capacity");

  // a taken request always stalls the input on the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input not stalled after accept");

  // a refused insert is never reported as a found query
  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.insert_full |-> !out_data.found)
    else $error("full and found both set");

endmodule
`default_nettype wire

/* hdl/omkp_store.sv */
// Single-port-write, single-port-read synchronous RAM holding the sorted entries.
// Read data is registered. No package dependency.
`default_nettype none
module omkp_store #(
  parameter int DEPTH = 1024,
  parameter int EW    = 34,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [EW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [EW-1:0] wr_data
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
